FILE: sv/pmrc_pkg.sv
// Shared types and constants of the poll master reply collector.
package pmrc_pkg;

    localparam int FRAME_BYTES = 7;
    localparam int REQ_BYTES   = 5;
    localparam int MAX_RES     = (FRAME_BYTES > REQ_BYTES) ? FRAME_BYTES : REQ_BYTES;

    localparam int CNT_W     = $clog2(FRAME_BYTES + 1);
    localparam int IDX_W     = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
    localparam int RES_CNT_W = $clog2(MAX_RES + 1);

    localparam logic [7:0] REQ_START  = 8'h02;
    localparam logic [7:0] REQ_ZERO   = 8'h00;
    localparam logic [7:0] REQ_STATUS = 8'h53;

    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_BYTE = 1'b1;

    localparam logic [2:0] REG_POLL_INTERVAL    = 3'd0;
    localparam logic [2:0] REG_REPLY_TIMEOUT    = 3'd1;
    localparam logic [2:0] REG_GAP_LIMIT        = 3'd2;
    localparam logic [2:0] REG_STATION_ADDRESS  = 3'd3;
    localparam logic [2:0] REG_POLL_COMMAND     = 3'd4;
    localparam logic [2:0] REG_FIRST_POLL_DELAY = 3'd5;

    typedef enum logic [1:0] {
        KIND_REQ     = 2'd0,
        KIND_FRAME   = 2'd1,
        KIND_FLUSH   = 2'd2,
        KIND_TIMEOUT = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
    } t_res;

endpackage

FILE: sv/poll_master_reply_collector_unit.sv
// Top level of the poll master reply collector: timing, polling, reply collection and output.

// Each accepted beat is worked in the cycle it arrives and may produce a burst of up to
// seven result beats (five request bytes, a full reply frame, or a flush and/or timeout
// report). Results leave one per cycle while i_ready is high, through a shifting output
// register, and one more burst can wait in a pending slot, so input beats are taken every
// cycle until that slot is occupied. A beat that causes results fills the pending slot,
// and its first result appears once the burst has moved from the pending slot into the
// output register. The block therefore takes one input beat per cycle for beats that
// cause no result; after a beat that causes results, input waits until the single output
// port frees and the burst leaves the pending slot. Configuration writes are taken in any
// cycle and are meant for times when no burst is out.
module poll_master_reply_collector_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_action,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_tx_ready,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_data,
    output logic        o_last
);

    logic [15:0] r_poll_interval;
    logic [15:0] r_reply_timeout;
    logic [15:0] r_gap_limit;
    logic [7:0]  r_station_address;
    logic [7:0]  r_poll_command;

    logic [31:0] r_clock, n_clock;
    logic        r_waiting, n_waiting;
    logic [31:0] r_next_poll, n_next_poll;
    logic [31:0] r_deadline, n_deadline;
    logic [pmrc_pkg::CNT_W-1:0] r_byte_count, n_byte_count;
    logic [31:0] r_last_byte_time, n_last_byte_time;
    logic [7:0]  r_store [pmrc_pkg::FRAME_BYTES];

    pmrc_pkg::t_res n_res [pmrc_pkg::MAX_RES];
    logic [pmrc_pkg::RES_CNT_W-1:0] n_res_cnt;

    logic           r_pend_valid;
    pmrc_pkg::t_res r_pend [pmrc_pkg::MAX_RES];
    logic [pmrc_pkg::RES_CNT_W-1:0] r_pend_cnt;

    pmrc_pkg::t_res r_emit [pmrc_pkg::MAX_RES];
    logic [pmrc_pkg::RES_CNT_W-1:0] r_emit_cnt;

    logic        in_acc;
    logic        out_acc;
    logic        cfg_acc;
    logic        emit_free;
    logic        flushed;
    logic [31:0] now;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = !r_pend_valid;
    assign in_acc      = i_valid && o_ready;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign o_valid     = (r_emit_cnt != '0);
    assign out_acc     = o_valid && i_ready;
    assign o_kind      = r_emit[0].kind;
    assign o_data      = r_emit[0].data;
    assign o_last      = (r_emit_cnt == pmrc_pkg::RES_CNT_W'(1));
    assign emit_free   = (r_emit_cnt == '0) || (o_last && out_acc);
    assign now         = r_clock + 32'd1;

    always_comb begin
        n_clock          = r_clock;
        n_waiting        = r_waiting;
        n_next_poll      = r_next_poll;
        n_deadline       = r_deadline;
        n_byte_count     = r_byte_count;
        n_last_byte_time = r_last_byte_time;
        n_res_cnt        = '0;
        flushed          = 1'b0;
        for (int i = 0; i < pmrc_pkg::MAX_RES; i++) begin
            n_res[i] = '{kind: pmrc_pkg::KIND_REQ, data: 8'd0};
        end
        if (in_acc) begin
            if (i_action == pmrc_pkg::ACT_BYTE) begin
                if (r_byte_count < pmrc_pkg::CNT_W'(pmrc_pkg::FRAME_BYTES)) begin
                    n_byte_count     = r_byte_count + pmrc_pkg::CNT_W'(1);
                    n_last_byte_time = r_clock;
                end
            end else begin
                n_clock = now;
                if (!r_waiting) begin
                    if (now >= r_next_poll) begin
                        if (i_tx_ready) begin
                            n_res[0]   = '{kind: pmrc_pkg::KIND_REQ, data: pmrc_pkg::REQ_START};
                            n_res[1]   = '{kind: pmrc_pkg::KIND_REQ, data: pmrc_pkg::REQ_ZERO};
                            n_res[2]   = '{kind: pmrc_pkg::KIND_REQ, data: r_station_address};
                            n_res[3]   = '{kind: pmrc_pkg::KIND_REQ, data: pmrc_pkg::REQ_STATUS};
                            n_res[4]   = '{kind: pmrc_pkg::KIND_REQ, data: r_poll_command};
                            n_res_cnt  = pmrc_pkg::RES_CNT_W'(pmrc_pkg::REQ_BYTES);
                            n_deadline = now + {16'd0, r_reply_timeout};
                            n_waiting  = 1'b1;
                        end else begin
                            n_next_poll = now + {16'd0, r_poll_interval};
                        end
                    end
                end else begin
                    if ((r_byte_count != '0) &&
                        ((now - r_last_byte_time) > {16'd0, r_gap_limit})) begin
                        n_res[0]         = '{kind: pmrc_pkg::KIND_FLUSH, data: 8'd0};
                        n_res_cnt        = pmrc_pkg::RES_CNT_W'(1);
                        flushed          = 1'b1;
                        n_byte_count     = '0;
                        n_last_byte_time = 32'd0;
                    end
                    if (n_byte_count >= pmrc_pkg::CNT_W'(pmrc_pkg::FRAME_BYTES)) begin
                        for (int i = 0; i < pmrc_pkg::FRAME_BYTES; i++) begin
                            n_res[i] = '{kind: pmrc_pkg::KIND_FRAME, data: r_store[i]};
                        end
                        n_res_cnt        = pmrc_pkg::RES_CNT_W'(pmrc_pkg::FRAME_BYTES);
                        n_byte_count     = '0;
                        n_last_byte_time = 32'd0;
                        n_next_poll      = now + {16'd0, r_poll_interval};
                        n_waiting        = 1'b0;
                    end else if (now >= r_deadline) begin
                        if (flushed) begin
                            n_res[1]  = '{kind: pmrc_pkg::KIND_TIMEOUT, data: 8'd0};
                            n_res_cnt = pmrc_pkg::RES_CNT_W'(2);
                        end else begin
                            n_res[0]  = '{kind: pmrc_pkg::KIND_TIMEOUT, data: 8'd0};
                            n_res_cnt = pmrc_pkg::RES_CNT_W'(1);
                        end
                        n_byte_count     = '0;
                        n_last_byte_time = 32'd0;
                        n_next_poll      = now + {16'd0, r_poll_interval};
                        n_waiting        = 1'b0;
                    end
                end
            end
        end
        if (cfg_acc && (i_cfg_index == pmrc_pkg::REG_FIRST_POLL_DELAY)) begin
            n_next_poll = {16'd0, i_cfg_data};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poll_interval    <= 16'd50;
            r_reply_timeout    <= 16'd10;
            r_gap_limit        <= 16'd10;
            r_station_address  <= 8'd1;
            r_poll_command     <= 8'd82;
            r_clock            <= 32'd0;
            r_waiting          <= 1'b0;
            r_next_poll        <= 32'd10;
            r_deadline         <= 32'd0;
            r_byte_count       <= '0;
            r_last_byte_time   <= 32'd0;
        end else begin
            r_clock          <= n_clock;
            r_waiting        <= n_waiting;
            r_next_poll      <= n_next_poll;
            r_deadline       <= n_deadline;
            r_byte_count     <= n_byte_count;
            r_last_byte_time <= n_last_byte_time;
            if (cfg_acc) begin
                case (i_cfg_index)
                    pmrc_pkg::REG_POLL_INTERVAL: begin
                        r_poll_interval <= i_cfg_data;
                    end
                    pmrc_pkg::REG_REPLY_TIMEOUT: begin
                        r_reply_timeout <= i_cfg_data;
                    end
                    pmrc_pkg::REG_GAP_LIMIT: begin
                        r_gap_limit <= i_cfg_data;
                    end
                    pmrc_pkg::REG_STATION_ADDRESS: begin
                        r_station_address <= i_cfg_data[7:0];
                    end
                    pmrc_pkg::REG_POLL_COMMAND: begin
                        r_poll_command <= i_cfg_data[7:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && (i_action == pmrc_pkg::ACT_BYTE) &&
            (r_byte_count < pmrc_pkg::CNT_W'(pmrc_pkg::FRAME_BYTES))) begin
            r_store[r_byte_count[pmrc_pkg::IDX_W-1:0]] <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_emit_cnt   <= '0;
        end else begin
            if (emit_free && r_pend_valid) begin
                r_pend_valid <= 1'b0;
                r_emit_cnt   <= r_pend_cnt;
            end else if (out_acc) begin
                r_emit_cnt <= r_emit_cnt - pmrc_pkg::RES_CNT_W'(1);
            end
            if (in_acc && (n_res_cnt != '0)) begin
                r_pend_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && (n_res_cnt != '0)) begin
            r_pend_cnt <= n_res_cnt;
            r_pend     <= n_res;
        end
        if (emit_free && r_pend_valid) begin
            r_emit <= r_pend;
        end else if (out_acc) begin
            for (int i = 0; i < pmrc_pkg::MAX_RES - 1; i++) begin
                r_emit[i] <= r_emit[i + 1];
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_byte_count <= pmrc_pkg::CNT_W'(pmrc_pkg::FRAME_BYTES))
        && (r_emit_cnt <= pmrc_pkg::RES_CNT_W'(pmrc_pkg::MAX_RES)))
        else $error("Buffer or burst count beyond its size.");

    a_poll_sent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_action == pmrc_pkg::ACT_TICK) && !r_waiting && i_tx_ready
         && (now >= r_next_poll))
        |=> (r_waiting && r_pend_valid
             && (r_pend_cnt == pmrc_pkg::RES_CNT_W'(pmrc_pkg::REQ_BYTES))))
        else $error("A due poll did not queue a request burst.");

    a_burst_unbroken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && !o_last) |=> o_valid)
        else $error("A result burst was broken before its last beat.");

    a_pend_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend_valid && (r_emit_cnt == '0)) |=> !r_pend_valid || (r_emit_cnt != '0))
        else $error("A pending burst was not moved into the idle output register.");

endmodule

FILE: bench/testbench.sv
// Self-checking testbench for the poll master reply collector unit.
`timescale 1ns / 1ps

module testbench;

    localparam int CLK_PERIOD      = 10;
    localparam int SETTLE_CYCLES   = 12;
    localparam int WATCHDOG_CYCLES = 1000;

    localparam logic [2:0] REG_SPARE_6 = 3'd6;
    localparam logic [2:0] REG_SPARE_7 = 3'd7;

    typedef struct {
        logic       action;
        logic [7:0] rx_byte;
        logic       tx_ready;
        logic       hold;
    } t_link_beat;

    typedef struct {
        pmrc_pkg::t_kind kind;
        logic [7:0]      data;
        logic            last;
    } t_link_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_action = 1'b0;
    logic [7:0]  i_rx_byte = '0;
    logic        i_tx_ready = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [1:0]  o_kind;
    logic [7:0]  o_data;
    logic        o_last;

    t_link_beat   pending_beats[$];
    t_link_result due_results[$];
    int           mismatches = 0;
    int           quiet_cycles = 0;

    logic [15:0] poll_every;
    logic [15:0] reply_window;
    logic [15:0] gap_allow;
    logic [7:0]  station_addr;
    logic [7:0]  poll_code;
    logic [15:0] first_due;

    logic [31:0] ms_clock;
    logic        awaiting_reply;
    logic [31:0] poll_due_at;
    logic [31:0] reply_due_at;
    int          rx_count;
    logic [31:0] rx_stamp;
    logic [7:0]  rx_frame[pmrc_pkg::FRAME_BYTES];

    poll_master_reply_collector_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_action    (i_action),
        .i_rx_byte   (i_rx_byte),
        .i_tx_ready  (i_tx_ready),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_kind      (o_kind),
        .o_data      (o_data),
        .o_last      (o_last)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic void reset_link_model();
        poll_every     = 16'd50;
        reply_window   = 16'd10;
        gap_allow      = 16'd10;
        station_addr   = 8'd1;
        poll_code      = 8'd82;
        first_due      = 16'd10;
        ms_clock       = '0;
        awaiting_reply = 1'b0;
        poll_due_at    = 32'd10;
        reply_due_at   = '0;
        rx_count       = 0;
        rx_stamp       = '0;
    endfunction

    function automatic void apply_reg(input logic [2:0] idx, input logic [15:0] val);
        case (idx)
            pmrc_pkg::REG_POLL_INTERVAL:    poll_every = val;
            pmrc_pkg::REG_REPLY_TIMEOUT:    reply_window = val;
            pmrc_pkg::REG_GAP_LIMIT:        gap_allow = val;
            pmrc_pkg::REG_STATION_ADDRESS:  station_addr = val[7:0];
            pmrc_pkg::REG_POLL_COMMAND:     poll_code = val[7:0];
            pmrc_pkg::REG_FIRST_POLL_DELAY: begin
                first_due = val;
                poll_due_at = {16'h0, val};
            end
            default: ;
        endcase
    endfunction

    function automatic void end_poll_cycle(input logic [31:0] now);
        rx_count = 0;
        rx_stamp = '0;
        poll_due_at = now + {16'h0, poll_every};
        awaiting_reply = 1'b0;
    endfunction

    function automatic void forecast_link_beat(input logic action, input logic [7:0] rxb,
                                               input logic txr);
        t_link_result burst[$];
        logic [31:0]  now;
        if (action == pmrc_pkg::ACT_BYTE) begin
            if (rx_count < pmrc_pkg::FRAME_BYTES) begin
                rx_frame[rx_count] = rxb;
                rx_count++;
                rx_stamp = ms_clock;
            end
            return;
        end
        ms_clock = ms_clock + 32'd1;
        now = ms_clock;
        if (!awaiting_reply) begin
            if (now >= poll_due_at) begin
                if (txr) begin
                    burst.push_back('{pmrc_pkg::KIND_REQ, pmrc_pkg::REQ_START, 1'b0});
                    burst.push_back('{pmrc_pkg::KIND_REQ, pmrc_pkg::REQ_ZERO, 1'b0});
                    burst.push_back('{pmrc_pkg::KIND_REQ, station_addr, 1'b0});
                    burst.push_back('{pmrc_pkg::KIND_REQ, pmrc_pkg::REQ_STATUS, 1'b0});
                    burst.push_back('{pmrc_pkg::KIND_REQ, poll_code, 1'b0});
                    reply_due_at = now + {16'h0, reply_window};
                    awaiting_reply = 1'b1;
                end else begin
                    poll_due_at = now + {16'h0, poll_every};
                end
            end
        end else begin
            if (rx_count != 0 && (now - rx_stamp) > {16'h0, gap_allow}) begin
                burst.push_back('{pmrc_pkg::KIND_FLUSH, 8'h00, 1'b0});
                rx_count = 0;
                rx_stamp = '0;
            end
            if (rx_count >= pmrc_pkg::FRAME_BYTES) begin
                foreach (rx_frame[i])
                    burst.push_back('{pmrc_pkg::KIND_FRAME, rx_frame[i], 1'b0});
                end_poll_cycle(now);
            end else if (now >= reply_due_at) begin
                burst.push_back('{pmrc_pkg::KIND_TIMEOUT, 8'h00, 1'b0});
                end_poll_cycle(now);
            end
        end
        if (burst.size() > 0)
            burst[burst.size() - 1].last = 1'b1;
        foreach (burst[i])
            due_results.push_back(burst[i]);
    endfunction

    function automatic void push_beat(input logic action, input logic [7:0] rxb,
                                      input logic txr, input logic hold);
        t_link_beat b;
        b.action = action;
        b.rx_byte = rxb;
        b.tx_ready = txr;
        b.hold = hold;
        pending_beats.push_back(b);
    endfunction

    function automatic void queue_exchange_traffic(input int beats, input int lead);
        int made;
        int n;
        int k;
        int i;
        made = 0;
        while (made < beats) begin
            if ($urandom_range(0, 9) == 0) begin
                push_beat(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)), 1'b0);
                made++;
            end else begin
                n = $urandom_range(1, lead);
                for (i = 0; i < n; i++) begin
                    push_beat(pmrc_pkg::ACT_TICK, 8'($urandom_range(0, 255)),
                              $urandom_range(0, 3) != 0,
                              i == 0 && $urandom_range(0, 19) == 0);
                    made++;
                end
                k = ($urandom_range(0, 9) < 7) ? pmrc_pkg::FRAME_BYTES
                                               : $urandom_range(0, pmrc_pkg::FRAME_BYTES + 2);
                for (i = 0; i < k; i++) begin
                    if ($urandom_range(0, 4) == 0) begin
                        push_beat(pmrc_pkg::ACT_TICK, 8'($urandom_range(0, 255)),
                                  1'($urandom_range(0, 1)), 1'b0);
                        made++;
                    end
                    push_beat(pmrc_pkg::ACT_BYTE, 8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)), 1'b0);
                    made++;
                end
                n = $urandom_range(1, 2);
                for (i = 0; i < n; i++) begin
                    push_beat(pmrc_pkg::ACT_TICK, 8'($urandom_range(0, 255)),
                              $urandom_range(0, 3) != 0, 1'b0);
                    made++;
                end
            end
        end
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_reg(idx, val);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        while (pending_beats.size() != 0 || i_valid || due_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_setting(input logic [15:0] interval, input logic [15:0] timeout,
                               input logic [15:0] gap, input logic [15:0] addr,
                               input logic [15:0] cmd, input logic [15:0] first,
                               input int beats, input int lead);
        write_reg(pmrc_pkg::REG_POLL_INTERVAL, interval);
        write_reg(pmrc_pkg::REG_REPLY_TIMEOUT, timeout);
        write_reg(pmrc_pkg::REG_GAP_LIMIT, gap);
        write_reg(pmrc_pkg::REG_STATION_ADDRESS, addr);
        write_reg(pmrc_pkg::REG_POLL_COMMAND, cmd);
        write_reg(pmrc_pkg::REG_FIRST_POLL_DELAY, first);
        queue_exchange_traffic(beats, lead);
        settle();
    endtask

    // Sender: presents queued beats with random gaps and updates the prediction on acceptance.
    int send_wait = 0;
    bit calm_send = 1'b0;
    t_link_beat next_beat;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            send_wait = 0;
        end else begin
            if (i_valid && o_ready) begin
                forecast_link_beat(i_action, i_rx_byte, i_tx_ready);
                if ($urandom_range(0, 31) == 0)
                    calm_send = !calm_send;
                send_wait = calm_send ? 0 : $urandom_range(0, 3);
            end
            if (!i_valid || o_ready) begin
                if (send_wait > 0) begin
                    send_wait--;
                    i_valid <= 1'b0;
                end else if (pending_beats.size() != 0 &&
                             (!pending_beats[0].hold || due_results.size() == 0)) begin
                    next_beat = pending_beats.pop_front();
                    i_valid    <= 1'b1;
                    i_action   <= next_beat.action;
                    i_rx_byte  <= next_beat.rx_byte;
                    i_tx_ready <= next_beat.tx_ready;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stalls at random and checks every result beat against the oldest expectation.
    int take_wait = 0;
    bit calm_take = 1'b0;
    t_link_result want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            take_wait = 0;
        end else begin
            if (o_valid && i_ready) begin
                if (due_results.size() == 0) begin
                    $error("result with no expectation: kind %0d data %02h last %b",
                           o_kind, o_data, o_last);
                    mismatches++;
                end else begin
                    want = due_results.pop_front();
                    if (o_kind !== want.kind) begin
                        $error("kind: expected %0d, actual %0d", want.kind, o_kind);
                        mismatches++;
                    end
                    if (o_data !== want.data) begin
                        $error("data: expected %02h, actual %02h", want.data, o_data);
                        mismatches++;
                    end
                    if (o_last !== want.last) begin
                        $error("last: expected %b, actual %b", want.last, o_last);
                        mismatches++;
                    end
                end
                if ($urandom_range(0, 31) == 0)
                    calm_take = !calm_take;
                take_wait = calm_take ? 0 : $urandom_range(0, 3);
            end
            if (take_wait > 0) begin
                take_wait--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("poll_master_reply_collector_unit regression: fail");
            $finish;
        end
    end

    initial begin : stimulus
        int i;
        reset_link_model();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: bytes while idle, a poll at the default due time, a stale partial
        // frame flushed, then an overfull reply delivered as one frame.
        push_beat(pmrc_pkg::ACT_BYTE, 8'hFF, 1'b1, 1'b0);
        push_beat(pmrc_pkg::ACT_BYTE, 8'h00, 1'b0, 1'b0);
        for (i = 0; i < 9; i++)
            push_beat(pmrc_pkg::ACT_TICK, i[0] ? 8'hFF : 8'h00, i[0], 1'b0);
        push_beat(pmrc_pkg::ACT_TICK, 8'hA5, 1'b1, 1'b0);
        push_beat(pmrc_pkg::ACT_TICK, 8'h00, 1'b1, 1'b0);
        push_beat(pmrc_pkg::ACT_BYTE, 8'hFF, 1'b0, 1'b0);
        push_beat(pmrc_pkg::ACT_BYTE, 8'h00, 1'b1, 1'b0);
        push_beat(pmrc_pkg::ACT_BYTE, 8'h80, 1'b0, 1'b0);
        push_beat(pmrc_pkg::ACT_BYTE, 8'h01, 1'b0, 1'b0);
        push_beat(pmrc_pkg::ACT_BYTE, 8'h55, 1'b0, 1'b0);
        push_beat(pmrc_pkg::ACT_BYTE, 8'hAA, 1'b0, 1'b0);
        push_beat(pmrc_pkg::ACT_BYTE, 8'h7E, 1'b0, 1'b0);
        push_beat(pmrc_pkg::ACT_BYTE, 8'h3C, 1'b1, 1'b0);
        push_beat(pmrc_pkg::ACT_TICK, 8'hFF, 1'b0, 1'b0);
        settle();

        // Tight timing: busy transmitter, flush and timeout on one tick, plain timeout.
        write_reg(pmrc_pkg::REG_POLL_INTERVAL, 16'd1);
        write_reg(pmrc_pkg::REG_REPLY_TIMEOUT, 16'd2);
        write_reg(pmrc_pkg::REG_GAP_LIMIT, 16'd0);
        write_reg(pmrc_pkg::REG_STATION_ADDRESS, 16'hFFFF);
        write_reg(pmrc_pkg::REG_POLL_COMMAND, 16'hFF00);
        write_reg(pmrc_pkg::REG_FIRST_POLL_DELAY, 16'd0);
        write_reg(REG_SPARE_6, 16'h1234);
        write_reg(REG_SPARE_7, 16'hEDCB);
        push_beat(pmrc_pkg::ACT_TICK, 8'h00, 1'b0, 1'b0);
        push_beat(pmrc_pkg::ACT_TICK, 8'h00, 1'b1, 1'b1);
        push_beat(pmrc_pkg::ACT_TICK, 8'h00, 1'b0, 1'b0);
        push_beat(pmrc_pkg::ACT_BYTE, 8'h5A, 1'b0, 1'b0);
        push_beat(pmrc_pkg::ACT_TICK, 8'h00, 1'b0, 1'b0);
        push_beat(pmrc_pkg::ACT_TICK, 8'h00, 1'b1, 1'b0);
        push_beat(pmrc_pkg::ACT_TICK, 8'h00, 1'b0, 1'b0);
        push_beat(pmrc_pkg::ACT_TICK, 8'h00, 1'b0, 1'b0);
        settle();

        run_setting(16'd3, 16'd6, 16'd2, 16'($urandom_range(0, 65535)),
                    16'($urandom_range(0, 65535)), 16'd0, 110, 5);
        run_setting(16'd1, 16'd1, 16'd0, 16'h0000, 16'h00FF, 16'd0, 90, 3);
        run_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h00FF, 16'h0000, 16'd0, 40, 3);
        run_setting(16'($urandom_range(1, 6)), 16'($urandom_range(2, 10)),
                    16'($urandom_range(0, 4)), 16'($urandom_range(0, 65535)),
                    16'($urandom_range(0, 65535)), 16'hFFFF, 30, 4);
        run_setting(16'd2, 16'd9, 16'd3, 16'($urandom_range(0, 65535)),
                    16'($urandom_range(0, 65535)), 16'd0, 150, 4);

        if (due_results.size() != 0) begin
            $error("%0d expected results never arrived", due_results.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("poll_master_reply_collector_unit regression: pass");
        else
            $display("poll_master_reply_collector_unit regression: fail");
        $finish;
    end

endmodule

FILE: sim.f
sv/pmrc_pkg.sv
sv/poll_master_reply_collector_unit.sv
bench/testbench.sv
